// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl tree
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/cbe_pkg.sv =====
`timescale 1ns / 1ps
package cbe_pkg;
  localparam int BisectStepsDef = 7;
  localparam int FracBitsDef    = 16;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 19;
  localparam int XW             = 17;
  localparam int YW             = 19;

  typedef enum logic [CfgIdxW-1:0] {
    REG_X1 = 2'd0,
    REG_Y1 = 2'd1,
    REG_X2 = 2'd2,
    REG_Y2 = 2'd3
  } cfg_reg_e;
endpackage

// ===== rtl/cubic_bezier_easing.sv =====
`timescale 1ns / 1ps
// pipeline: five stages per bisection step, one stage per quotient bit of the
//   interpolation divider
// throughput: one transfer per cycle; the whole pipe advances when the output is free
// reset: rst_ni async active low clears all valid bits and loads the default control points
`include "assert_macros.svh"
module cubic_bezier_easing
  import cbe_pkg::*;
#(
  parameter int BISECT_STEPS = BisectStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // progress [16:0]
  input  logic [23:0]         s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // eased_value [18:0]
  output logic [23:0]         m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  localparam int F   = FracBitsDef;
  localparam int NW  = 2 * F + 6;   // |t - xa| * |yb - ya| magnitude
  localparam int DW  = F + 2;
  localparam int ONE = 1 << F;

  // control point registers, x saturated to one on write
  logic [F:0] x1_q, x2_q;
  logic signed [F+2:0] y1_q, y2_q;
  logic [XW-1:0] cx_d;
  assign cx_d = (cfg_data_i[XW-1:0] > XW'(65536)) ? XW'(65536) : cfg_data_i[XW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= (F+1)'(ONE / 4);
      y1_q <= (F+3)'(6554 << (F - 16) >> 0);
      x2_q <= (F+1)'(ONE / 4);
      y2_q <= (F+3)'(ONE);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_X1:  x1_q <= (F+1)'(cx_d);
        REG_Y1:  y1_q <= (F+3)'($signed(cfg_data_i));
        REG_X2:  x2_q <= (F+1)'(cx_d);
        REG_Y2:  y2_q <= (F+3)'($signed(cfg_data_i));
        default: ;
      endcase
    end
  end

  // output register with global stall: the pipe moves when the output is empty or taken
  logic en;
  logic out_v_q;
  logic [YW-1:0] out_q;
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // entry: progress clamp to one; special cases are detected from t after the bisection
  logic [F:0] t_in;
  logic in_v;
  assign in_v = s_axis_tvalid && en;
  assign t_in = (s_axis_tdata[16:0] >= 17'(ONE)) ? (F+1)'(ONE) : (F+1)'(s_axis_tdata[16:0]);

  logic [F:0] t_c [BISECT_STEPS+1];
  logic [F:0] sa_c [BISECT_STEPS+1];
  logic [F:0] sb_c [BISECT_STEPS+1];
  logic [F+1:0] xa_c [BISECT_STEPS+1];
  logic [F+1:0] xb_c [BISECT_STEPS+1];
  logic signed [F+3:0] ya_c [BISECT_STEPS+1];
  logic signed [F+3:0] yb_c [BISECT_STEPS+1];
  logic v_c [BISECT_STEPS+1];

  assign t_c[0]  = t_in;
  assign sa_c[0] = '0;
  assign sb_c[0] = (F+1)'(ONE);
  assign xa_c[0] = '0;
  assign ya_c[0] = '0;
  assign xb_c[0] = (F+2)'(ONE);
  assign yb_c[0] = (F+4)'(ONE);
  assign v_c[0]  = in_v;

  for (genvar i = 0; i < BISECT_STEPS; i++) begin : g_bis
    cbe_curve_stage #(.F(F)) u_step (
      .clk_i, .rst_ni, .en_i(en), .valid_i(v_c[i]),
      .t_i(t_c[i]), .sa_i(sa_c[i]), .sb_i(sb_c[i]),
      .xa_i(xa_c[i]), .ya_i(ya_c[i]), .xb_i(xb_c[i]), .yb_i(yb_c[i]),
      .x1_i(x1_q), .y1_i(y1_q), .x2_i(x2_q), .y2_i(y2_q),
      .valid_o(v_c[i+1]), .t_o(t_c[i+1]), .sa_o(sa_c[i+1]), .sb_o(sb_c[i+1]),
      .xa_o(xa_c[i+1]), .ya_o(ya_c[i+1]), .xb_o(xb_c[i+1]), .yb_o(yb_c[i+1])
    );
  end

  // interpolation setup: special cases give a zero numerator, t at 0 or 1 a fixed base
  localparam int B = BISECT_STEPS;
  logic signed [F+4:0] dx_d, dy_d, tx_d;
  logic signed [F+3:0] base_d;
  logic zero_num;
  logic [NW-1:0] num_d;
  logic [2*F+9:0] prod_d;
  assign dx_d = $signed({3'b000, xb_c[B]}) - $signed({3'b000, xa_c[B]});
  assign dy_d = yb_c[B] - ya_c[B];
  assign tx_d = $signed({4'b0000, t_c[B]}) - $signed({3'b000, xa_c[B]});
  assign zero_num = (t_c[B] == '0) || (t_c[B] == (F+1)'(ONE)) || (dx_d <= 0);
  assign base_d = (t_c[B] == '0) ? '0 :
                  (t_c[B] == (F+1)'(ONE)) ? (F+4)'(ONE) : ya_c[B];

  logic v_m_q, neg_m_q, zero_m_q;
  logic [F+4:0] atx_q, ady_q;
  logic [DW-1:0] den_m_q;
  logic signed [F+3:0] base_m_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_m_q <= 1'b0;
    else if (en) v_m_q <= v_c[B];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      atx_q    <= tx_d[F+4] ? (F+5)'(-tx_d) : tx_d;
      ady_q    <= dy_d[F+4] ? (F+5)'(-dy_d) : dy_d;
      neg_m_q  <= tx_d[F+4] ^ dy_d[F+4];
      zero_m_q <= zero_num;
      den_m_q  <= zero_num ? DW'(1) : dx_d[DW-1:0];
      base_m_q <= base_d;
    end
  end

  assign prod_d = atx_q * ady_q;
  logic v_p_q, neg_p_q;
  logic [NW-1:0] num_p_q;
  logic [DW-1:0] den_p_q;
  logic signed [F+3:0] base_p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_p_q <= 1'b0;
    else if (en) v_p_q <= v_m_q;
  end
  assign num_d = zero_m_q ? '0 : prod_d[NW-1:0];
  always_ff @(posedge clk_i) begin
    if (en) begin
      num_p_q  <= num_d;
      den_p_q  <= den_m_q;
      neg_p_q  <= neg_m_q;
      base_p_q <= base_m_q;
    end
  end

  logic v_dv, rnz_dv, neg_dv;
  logic [NW-1:0] quo_dv;
  logic signed [F+3:0] base_dv;
  cbe_divider #(.NW(NW), .DW(DW), .SW(F+4)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_p_q),
    .num_i(num_p_q), .den_i(den_p_q), .neg_i(neg_p_q), .side_i(base_p_q),
    .valid_o(v_dv), .quo_o(quo_dv), .rem_nz_o(rnz_dv), .neg_o(neg_dv), .side_o(base_dv)
  );

  // floor of a negative quotient rounds away from zero when a remainder is left
  logic signed [NW+1:0] q_s, res_d;
  logic [YW-1:0] sat_d;
  assign q_s = neg_dv ? -$signed({2'b00, quo_dv}) - (rnz_dv ? 1 : 0)
                      : $signed({2'b00, quo_dv});
  assign res_d = q_s + (NW+2)'(base_dv);
  assign sat_d = (res_d < -$signed((NW+2)'(2 * ONE))) ? YW'(-(2 * ONE)) :
                 (res_d > $signed((NW+2)'(3 * ONE))) ? YW'(3 * ONE) : res_d[YW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= v_dv;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= sat_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b00000, out_q};

  // a stalled result holds its value
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_v_q && !m_axis_tready, out_v_q && $stable(out_q),
               "stalled result changed")
  // ready follows the output register state
  `ASSERT_IMPL(a_rdy, clk_i, rst_ni, s_axis_tready == (!out_v_q || m_axis_tready),
               "ready mismatch")
  // divider denominator never zero
  `ASSERT_IMPL(a_den, clk_i, rst_ni, !v_p_q || den_p_q != '0, "zero divisor")
endmodule

// ===== rtl/cbe_divider.sv =====
`timescale 1ns / 1ps
// pipelined restoring floor divider, one quotient bit per stage
module cbe_divider
  import cbe_pkg::*;
#(
  parameter int NW = 40,
  parameter int DW = 20,
  parameter int SW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [NW-1:0]        num_i,
  input  logic [DW-1:0]        den_i,
  input  logic                 neg_i,
  input  logic signed [SW-1:0] side_i,
  output logic                 valid_o,
  output logic [NW-1:0]        quo_o,
  output logic                 rem_nz_o,
  output logic                 neg_o,
  output logic signed [SW-1:0] side_o
);
  logic [NW:0]                 v_q;
  logic [NW-1:0]               q_q   [NW+1];
  logic [DW:0]                 r_q   [NW+1];
  logic [DW-1:0]               d_q   [NW+1];
  logic                        n_q   [NW+1];
  logic signed [SW-1:0]        s_q   [NW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[NW-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q[0] <= num_i;
      r_q[0] <= '0;
      d_q[0] <= den_i;
      n_q[0] <= neg_i;
      s_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [DW+1:0] sh_d;
    logic [DW+1:0] df_d;
    assign sh_d = {r_q[k], q_q[k][NW-1]};
    assign df_d = sh_d - {2'b00, d_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!df_d[DW+1]) begin
          r_q[k+1] <= df_d[DW:0];
          q_q[k+1] <= {q_q[k][NW-2:0], 1'b1};
        end else begin
          r_q[k+1] <= sh_d[DW:0];
          q_q[k+1] <= {q_q[k][NW-2:0], 1'b0};
        end
        d_q[k+1] <= d_q[k];
        n_q[k+1] <= n_q[k];
        s_q[k+1] <= s_q[k];
      end
    end
  end

  assign valid_o  = v_q[NW];
  assign quo_o    = q_q[NW];
  assign rem_nz_o = |r_q[NW];
  assign neg_o    = n_q[NW];
  assign side_o   = s_q[NW];
endmodule

// ===== rtl/cbe_curve_stage.sv =====
`timescale 1ns / 1ps
// one bisection step: curve point at midpoint, then the half that holds t is kept
module cbe_curve_stage
  import cbe_pkg::*;
#(
  parameter int F = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [F:0]          t_i,
  input  logic [F:0]          sa_i,
  input  logic [F:0]          sb_i,
  input  logic [F+1:0]        xa_i,
  input  logic signed [F+3:0] ya_i,
  input  logic [F+1:0]        xb_i,
  input  logic signed [F+3:0] yb_i,
  input  logic [F:0]          x1_i,
  input  logic signed [F+2:0] y1_i,
  input  logic [F:0]          x2_i,
  input  logic signed [F+2:0] y2_i,
  output logic                valid_o,
  output logic [F:0]          t_o,
  output logic [F:0]          sa_o,
  output logic [F:0]          sb_o,
  output logic [F+1:0]        xa_o,
  output logic signed [F+3:0] ya_o,
  output logic [F+1:0]        xb_o,
  output logic signed [F+3:0] yb_o
);
  typedef struct packed {
    logic [F:0]          t;
    logic [F:0]          sa;
    logic [F:0]          sb;
    logic [F+1:0]        xa;
    logic signed [F+3:0] ya;
    logic [F+1:0]        xb;
    logic signed [F+3:0] yb;
  } ctx_t;

  // weights and curve values stay within [0, ~1.5] and [-6, 9] in real terms
  localparam int PW = 2 * F + 4;

  logic [3:0] v_q;
  ctx_t c1_q, c2_q, c3_q, c4_q;
  logic [F:0] sm1_q, u1_q;
  logic [F:0] s2_2_q, u2_2_q, sm2_q, u2q_q;
  logic [F+2:0] w1_3_q, w2_3_q;
  logic [F:0] s3_3_q;
  logic [F:0] sm3_q, sm4_q;
  logic signed [PW+2:0] px_q, py_q;
  logic [F:0] s3_4_q;

  logic [F:0] mid_d;
  logic [2*F+1:0] p_ss, p_uu, p_s2s, p_su2, p_s2u;
  assign mid_d = (F+1)'(({1'b0, sa_i} + {1'b0, sb_i}) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[2:0], valid_i};
  end

  assign p_ss = sm1_q * sm1_q;
  assign p_uu = u1_q * u1_q;
  assign p_s2s = s2_2_q * sm2_q;
  assign p_su2 = sm2_q * u2q_q;
  assign p_s2u = s2_2_q * u2_2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q   <= '{t_i, sa_i, sb_i, xa_i, ya_i, xb_i, yb_i};
      sm1_q  <= mid_d;
      u1_q   <= (F+1)'(1 << F) - mid_d;
      c2_q   <= c1_q;
      sm2_q  <= sm1_q;
      u2_2_q <= u1_q;
      s2_2_q <= p_ss[2*F:F];
      u2q_q  <= p_uu[2*F:F];
      c3_q   <= c2_q;
      sm3_q  <= sm2_q;
      s3_3_q <= p_s2s[2*F:F];
      w1_3_q <= (F+3)'(3) * {2'b00, p_su2[2*F:F]};
      w2_3_q <= (F+3)'(3) * {2'b00, p_s2u[2*F:F]};
      c4_q   <= c3_q;
      sm4_q  <= sm3_q;
      s3_4_q <= s3_3_q;
      px_q   <= (PW+3)'($signed({1'b0, w1_3_q}) * $signed({1'b0, x1_i}))
              + (PW+3)'($signed({1'b0, w2_3_q}) * $signed({1'b0, x2_i}));
      py_q   <= (PW+3)'($signed({1'b0, w1_3_q}) * y1_i)
              + (PW+3)'($signed({1'b0, w2_3_q}) * y2_i);
    end
  end

  logic signed [F+3:0] xm_d, ym_d;
  logic keep_low;
  assign xm_d = (F+4)'(px_q >>> F) + $signed({3'b000, s3_4_q});
  assign ym_d = (F+4)'(py_q >>> F) + $signed({3'b000, s3_4_q});
  assign keep_low = $signed({3'b000, c4_q.t}) <= xm_d;

  ctx_t out_q, out_d;
  logic vo_q;

  // keep the half whose x range holds t
  always_comb begin
    out_d = c4_q;
    if (keep_low) begin
      out_d.sb = sm4_q;
      out_d.xb = xm_d[F+1:0];
      out_d.yb = ym_d;
    end else begin
      out_d.sa = sm4_q;
      out_d.xa = xm_d[F+1:0];
      out_d.ya = ym_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en_i) vo_q <= v_q[3];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= out_d;
  end

  assign valid_o = vo_q;
  assign t_o  = out_q.t;
  assign sa_o = out_q.sa;
  assign sb_o = out_q.sb;
  assign xa_o = out_q.xa;
  assign ya_o = out_q.ya;
  assign xb_o = out_q.xb;
  assign yb_o = out_q.yb;
endmodule
